// ----- rtl/core/nsr_pkg.sv -----
// Shared types, constants and helper functions for the named service registry.
// Used by the interfaces, the front and back modules and the top level.
package nsr_pkg;

    // Field widths of one request and one response transaction.
    localparam int LO_W     = 64;
    localparam int HI_W     = 56;
    localparam int LEN_W    = 5;
    localparam int PID_W    = 7;
    localparam int LIVE_W   = 64;
    localparam int SLOT_PID_W = 6;

    // Table geometry.
    localparam int SLOTS_DEF  = 16;
    localparam int NAME_CHARS = 15;
    localparam int PROCS      = 64;
    localparam int QDEPTH     = 2;

    // A found_pid of all ones means no process.
    localparam logic [PID_W-1:0] PID_NONE = '1;

    // Request codes.
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_LOOKUP   = 1'b1;

    // Characters allowed in a registered name.
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Work that the front hands to the back.
    typedef enum logic [1:0] {
        OP_FAIL,    // answer at once with ok low and no pid
        OP_REG,     // register: update a match or claim a free slot
        OP_LOOK,    // lookup: free stale slots, stop at first live match
        OP_SWEEP    // overlong lookup: free stale slots, match nothing
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [SLOT_PID_W-1:0] pid;
        logic [LIVE_W-1:0]     live;
        logic [HI_W-1:0]       name_hi;
        logic [LO_W-1:0]       name_lo;
    } cmd_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } bk_state_t;

    // True for a letter, a digit, a hyphen or an underscore.
    function automatic logic byte_ok(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               (c >= CH_DIG_0 && c <= CH_DIG_9) || c == CH_DASH || c == CH_UNDER;
    endfunction

endpackage

// ----- rtl/core/nsr_req_if.sv -----
// Request channel of the named service registry: valid, ready and payload.
// Depends on nsr_pkg for the field widths.
interface nsr_req_if;
    import nsr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [LO_W-1:0]          name_lo;
    logic [HI_W-1:0]          name_hi;
    logic [LEN_W-1:0]         name_len;
    logic signed [PID_W-1:0]  proc_id;
    logic [LIVE_W-1:0]        live_mask;

    modport source (
        output valid, req_type, name_lo, name_hi, name_len, proc_id, live_mask,
        input  ready
    );

    modport sink (
        input  valid, req_type, name_lo, name_hi, name_len, proc_id, live_mask,
        output ready
    );
endinterface

// ----- rtl/core/nsr_rsp_if.sv -----
// Response channel of the named service registry: valid, ready and payload.
// Depends on nsr_pkg for the field widths.
interface nsr_rsp_if;
    import nsr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [PID_W-1:0]  found_pid;

    modport source (
        output valid, ok, found_pid,
        input  ready
    );

    modport sink (
        input  valid, ok, found_pid,
        output ready
    );
endinterface

// ----- rtl/core/nsr_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module nsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/nsr_front.sv -----
// Front end of the registry: accepts request transactions, checks and masks
// the name and the pid, and queues a command for the back end. Uses nsr_pkg.
module nsr_front (
    input  logic          clk,
    input  logic          rst_n,
    nsr_req_if.sink       req,
    output nsr_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_pop
);
    import nsr_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [LO_W-1:0]        lo_masked;
    logic [HI_W-1:0]        hi_masked;
    logic                   fits;
    logic                   bad_byte;
    logic                   pid_ok;
    logic [SLOT_PID_W-1:0]  pid_low;
    cmd_t                   cmd_in;

    cmd_t                   q_reg [QDEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   push;
    logic                   pop;

    // Mask the bytes past the length and check each byte within it.
    always_comb
    begin
        lo_masked = '0;
        hi_masked = '0;
        bad_byte  = 1'b0;
        for (int i = 0; i < LO_W / 8; i++)
        begin
            if (LEN_W'(i) < req.name_len)
            begin
                lo_masked[8*i +: 8] = req.name_lo[8*i +: 8];
                if (!byte_ok(req.name_lo[8*i +: 8]))
                begin
                    bad_byte = 1'b1;
                end
            end
        end
        for (int i = 0; i < HI_W / 8; i++)
        begin
            if (LEN_W'(i + LO_W / 8) < req.name_len)
            begin
                hi_masked[8*i +: 8] = req.name_hi[8*i +: 8];
                if (!byte_ok(req.name_hi[8*i +: 8]))
                begin
                    bad_byte = 1'b1;
                end
            end
        end
    end

    // Length and pid checks.
    assign fits    = (req.name_len != '0) && (req.name_len <= LEN_W'(NAME_CHARS));
    assign pid_low = req.proc_id[SLOT_PID_W-1:0];
    assign pid_ok  = !req.proc_id[PID_W-1] &&
                     ({1'b0, pid_low} < PID_W'(PROCS)) &&
                     req.live_mask[pid_low];

    // Classify the transaction into the command for the back end.
    always_comb
    begin
        cmd_in.pid     = pid_low;
        cmd_in.live    = req.live_mask;
        cmd_in.name_hi = hi_masked;
        cmd_in.name_lo = lo_masked;
        if (req.req_type == REQ_REGISTER)
        begin
            cmd_in.op = (fits && pid_ok && !bad_byte) ? OP_REG : OP_FAIL;
        end
        else if (req.name_len == '0)
        begin
            cmd_in.op = OP_FAIL;
        end
        else
        begin
            cmd_in.op = fits ? OP_LOOK : OP_SWEEP;
        end
    end

    // Command queue between the front and the back.
    assign req.ready = (cnt_reg != CNT_W'(QDEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ----- rtl/core/nsr_back.sv -----
// Back end of the registry: walks the slot table one slot per cycle for each
// queued command and holds the response register. Uses nsr_pkg and nsr_ram.
module nsr_back #(
    parameter int SLOTS = nsr_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  nsr_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    nsr_rsp_if.source     rsp
);
    import nsr_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WORD_W = SLOT_PID_W + HI_W + LO_W;

    bk_state_t              state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   pend_reg, pend_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic                   res_ok_reg, res_ok_next;
    logic [PID_W-1:0]       res_pid_reg, res_pid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_ok_reg, out_ok_next;
    logic [PID_W-1:0]       out_pid_reg, out_pid_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;

    logic [SLOT_PID_W-1:0]  slot_pid;
    logic [HI_W-1:0]        slot_hi;
    logic [LO_W-1:0]        slot_lo;
    logic                   slot_vld;
    logic                   slot_live;
    logic                   name_eq;
    logic                   eval;
    logic                   last;
    logic                   reg_hit;
    logic                   look_hit;
    logic                   scan_end;
    logic                   out_free;
    logic                   has_free;
    logic [IDX_W-1:0]       free_idx;

    // Slot names and pids live in one RAM word per slot.
    nsr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Decode the slot word that returned from the RAM this cycle.
    assign slot_pid  = ram_rdata[WORD_W-1 -: SLOT_PID_W];
    assign slot_hi   = ram_rdata[LO_W +: HI_W];
    assign slot_lo   = ram_rdata[LO_W-1:0];
    assign slot_vld  = valid_reg[cmp_idx_reg];
    assign slot_live = ({1'b0, slot_pid} < PID_W'(PROCS)) && cmd_reg.live[slot_pid];
    assign name_eq   = (slot_lo == cmd_reg.name_lo) && (slot_hi == cmd_reg.name_hi);
    assign eval      = (state_reg == BK_SCAN) && pend_reg;
    assign last      = (cmp_idx_reg == IDX_W'(SLOTS - 1));
    assign reg_hit   = eval && (cmd_reg.op == OP_REG) && slot_vld && name_eq;
    assign look_hit  = eval && (cmd_reg.op == OP_LOOK) && slot_vld && slot_live && name_eq;
    assign scan_end  = eval && (reg_hit || look_hit || last);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Lowest free slot, from the valid bits.
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end
    assign has_free = !(&valid_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.op == OP_FAIL) ? BK_DONE : BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath updates.
    always_comb
    begin
        cmd_pop        = 1'b0;
        cmd_next       = cmd_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = 1'b0;
        valid_next     = valid_reg;
        res_ok_next    = res_ok_reg;
        res_pid_next   = res_pid_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_pid_next   = out_pid_reg;
        ram_we         = 1'b0;
        ram_waddr      = cmp_idx_reg;
        ram_wdata      = {cmd_reg.pid, cmd_reg.name_hi, cmd_reg.name_lo};

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_pop      = 1'b1;
                cmd_next     = cmd;
                rd_idx_next  = '0;
                res_ok_next  = 1'b0;
                res_pid_next = PID_NONE;
            end
            BK_SCAN:
            begin
                // Issue one slot read per cycle until every slot is read.
                if (rd_idx_reg < CNT_W'(SLOTS))
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end
                if (eval)
                begin
                    if (cmd_reg.op == OP_REG)
                    begin
                        // Rewrite a matching slot, or claim the lowest free one at the end.
                        if (reg_hit)
                        begin
                            ram_we      = 1'b1;
                            res_ok_next = 1'b1;
                        end
                        else if (last && has_free)
                        begin
                            ram_we               = 1'b1;
                            ram_waddr            = free_idx;
                            valid_next[free_idx] = 1'b1;
                            res_ok_next          = 1'b1;
                        end
                    end
                    else if (slot_vld && !slot_live)
                    begin
                        // A lookup frees a slot whose process is gone.
                        valid_next[cmp_idx_reg] = 1'b0;
                    end
                    else if (look_hit)
                    begin
                        res_ok_next  = 1'b1;
                        res_pid_next = {1'b0, slot_pid};
                    end
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_pid_next   = res_pid_reg;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cmp_idx_reg <= cmp_idx_next;
        res_ok_reg  <= res_ok_next;
        res_pid_reg <= res_pid_next;
        out_ok_reg  <= out_ok_next;
        out_pid_reg <= out_pid_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.ok        = out_ok_reg;
    assign rsp.found_pid = out_pid_reg;

endmodule

// ----- rtl/core/named_service_registry_table.sv -----
// Top level of the named service registry table.
// Depends on nsr_pkg, nsr_req_if, nsr_rsp_if, nsr_front and nsr_back.
//
// Usage: a table of SLOTS slots maps a name of one to fifteen bytes to a pid.
// Requests arrive on the req channel (valid/ready); each transaction is a
// register or a lookup and carries a snapshot of live processes. Exactly one
// response transaction (ok, found_pid) leaves on the rsp channel per request,
// in request order.
// Timing: a request that the front turns away as failed skips the slot scan;
// any other request reads every slot up to its stopping point from the slot
// RAM, one slot per cycle. The single read port of the slot RAM sets this pace,
// and the back works on one request at a time.
// A two-entry command queue lets the front accept requests while the back
// scans, and the response register lets the back finish a request while the
// receiver stalls; req.ready falls whenever the queue holds two commands.
// Reset empties the table and the queue and drops any pending response;
// the slot RAM needs no clearing pass.
module named_service_registry_table #(
    parameter int SLOTS = nsr_pkg::SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    nsr_req_if.sink    req,
    nsr_rsp_if.source  rsp
);
    import nsr_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // Checks, masking and command queue.
    nsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // Slot scan engine and response register.
    nsr_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

// ----- tb/nsr_registry_checker.sv -----
`timescale 1ns / 1ps
// Checker for the named service registry: watches both channels, keeps its own copy
// of the slot table and compares each response with the predicted outcome.
// Depends on nsr_pkg, nsr_req_if and nsr_rsp_if.
module nsr_registry_checker
    import nsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    nsr_req_if   req,
    nsr_rsp_if   rsp,
    output int   errors,
    output int   outstanding,
    output int   checked,
    output int   reg_granted,
    output int   lookup_hits
);

    typedef struct packed {
        logic             ok;
        logic [PID_W-1:0] pid;
    } outcome_t;

    // Shadow copy of the slot table.
    logic [SLOTS_DEF-1:0]  tbl_used;
    logic [SLOT_PID_W-1:0] tbl_pid [SLOTS_DEF];
    logic [LO_W-1:0]       tbl_lo  [SLOTS_DEF];
    logic [HI_W-1:0]       tbl_hi  [SLOTS_DEF];

    // Outcomes of accepted requests, oldest first.
    outcome_t outcomes_due[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic logic name_char_legal(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               (c >= CH_DIG_0 && c <= CH_DIG_9) || (c == CH_DASH) || (c == CH_UNDER);
    endfunction

    function automatic logic proc_is_live(input logic [PID_W-1:0] pid,
                                          input logic [LIVE_W-1:0] live);
        if (pid >= PROCS)
            return 1'b0;
        return live[pid[SLOT_PID_W-1:0]];
    endfunction

    // Applies one request to the shadow table and returns the response it must give.
    function automatic outcome_t registry_outcome(input logic kind,
                                                  input logic [LO_W-1:0] lo,
                                                  input logic [HI_W-1:0] hi,
                                                  input logic [LEN_W-1:0] len,
                                                  input logic [PID_W-1:0] pid,
                                                  input logic [LIVE_W-1:0] live);
        outcome_t  res;
        int        n;
        int        i;
        int        s;
        int        open_slot;
        logic      fits;
        logic [7:0] c;
        logic [LO_W-1:0] mlo;
        logic [HI_W-1:0] mhi;

        res.ok = 1'b0;
        res.pid = PID_NONE;
        n = int'(len);
        fits = (n >= 1) && (n <= NAME_CHARS);

        // Bytes past the length do not take part in the name.
        if (fits)
        begin
            if (n >= 8)
                mlo = '1;
            else
                mlo = (64'd1 << (8 * n)) - 64'd1;
            if (n <= 8)
                mhi = '0;
            else
                mhi = (56'd1 << (8 * (n - 8))) - 56'd1;
            lo = lo & mlo;
            hi = hi & mhi;
        end

        if (kind == REQ_REGISTER)
        begin
            if (!fits || pid[PID_W-1] || !proc_is_live(pid, live))
                return res;
            for (i = 0; i < n; i++)
            begin
                if (i < 8)
                    c = lo[8*i +: 8];
                else
                    c = hi[8*(i-8) +: 8];
                if (!name_char_legal(c))
                    return res;
            end
            // A slot with the same name is rewritten; otherwise the lowest free one is taken.
            open_slot = -1;
            for (s = 0; s < SLOTS_DEF; s++)
            begin
                if (tbl_used[s])
                begin
                    if (tbl_lo[s] == lo && tbl_hi[s] == hi)
                    begin
                        tbl_pid[s] = pid[SLOT_PID_W-1:0];
                        res.ok = 1'b1;
                        return res;
                    end
                end
                else if (open_slot < 0)
                begin
                    open_slot = s;
                end
            end
            if (open_slot >= 0)
            begin
                tbl_used[open_slot] = 1'b1;
                tbl_pid[open_slot] = pid[SLOT_PID_W-1:0];
                tbl_lo[open_slot] = lo;
                tbl_hi[open_slot] = hi;
                res.ok = 1'b1;
            end
            return res;
        end

        // A lookup frees dead slots on its way and stops at the first live match.
        if (n == 0)
            return res;
        for (s = 0; s < SLOTS_DEF; s++)
        begin
            if (!tbl_used[s])
                continue;
            if (!proc_is_live({1'b0, tbl_pid[s]}, live))
            begin
                tbl_used[s] = 1'b0;
                continue;
            end
            if (fits && tbl_lo[s] == lo && tbl_hi[s] == hi)
            begin
                res.ok = 1'b1;
                res.pid = {1'b0, tbl_pid[s]};
                return res;
            end
        end
        return res;
    endfunction

    // Responses are compared before the request of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t due;
        outcome_t fresh;
        if (!rst_n)
        begin
            errors = 0;
            outstanding = 0;
            checked = 0;
            reg_granted = 0;
            lookup_hits = 0;
            tbl_used = '0;
            outcomes_due.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                checked++;
                if (outcomes_due.size() == 0)
                begin
                    report_mismatch($sformatf("response ok=%0b found_pid=%0d with no request waiting",
                                              rsp.ok, rsp.found_pid));
                end
                else
                begin
                    due = outcomes_due.pop_front();
                    if (rsp.ok !== due.ok)
                        report_mismatch($sformatf("ok is %0b, predicted %0b", rsp.ok, due.ok));
                    if (rsp.found_pid !== due.pid)
                        report_mismatch($sformatf("found_pid is %0d, predicted %0d",
                                                  rsp.found_pid, $signed(due.pid)));
                end
            end
            if (req.valid && req.ready)
            begin
                fresh = registry_outcome(req.req_type, req.name_lo, req.name_hi, req.name_len,
                                         req.proc_id, req.live_mask);
                outcomes_due.push_back(fresh);
                if (fresh.ok)
                begin
                    if (req.req_type == REQ_LOOKUP)
                        lookup_hits++;
                    else
                        reg_granted++;
                end
            end
            outstanding = outcomes_due.size();
        end
    end

endmodule

// ----- tb/tb_named_service_registry_table.sv -----
`timescale 1ns / 1ps
// Top of the registry testbench: clock, reset, request stimulus and response back-pressure.
// Depends on nsr_pkg, both channel interfaces, the registry table and nsr_registry_checker.
module tb_named_service_registry_table;
    import nsr_pkg::*;

    localparam int NAME_W          = LO_W + HI_W;
    localparam int POOL_SIZE       = 24;
    localparam int PHASES          = 4;
    localparam int ITEMS_PER_PHASE = 212;
    localparam int BURST_ITEMS     = 24;
    localparam int RX_HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES    = 40;

    // Bytes just outside the legal character ranges, plus zero, space and all ones.
    localparam logic [7:0] BAD_BYTES [12] = '{8'h00, 8'h20, 8'h2C, 8'h2E, 8'h2F, 8'h3A,
                                              8'h40, 8'h5B, 8'h5E, 8'h60, 8'h7B, 8'hFF};

    logic clk;
    logic rst_n;

    nsr_req_if req ();
    nsr_rsp_if rsp ();

    int errors;
    int outstanding;
    int checked;
    int reg_granted;
    int lookup_hits;
    int sent = 0;

    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    logic rx_hold   = 1'b0;

    logic [NAME_W-1:0] pool_name [POOL_SIZE];
    int                pool_len  [POOL_SIZE];
    logic [LIVE_W-1:0] world_live;

    named_service_registry_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    nsr_registry_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .reg_granted (reg_granted),
        .lookup_hits (lookup_hits)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Pids cluster in the low range so that deaths hit registered slots often.
    function automatic int pick_pid();
        if ($urandom_range(0, 4) != 0)
            return $urandom_range(0, 15);
        return $urandom_range(0, PROCS - 1);
    endfunction

    function automatic logic [7:0] legal_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26)
            return CH_LOW_A + 8'(r);
        if (r < 52)
            return CH_UP_A + 8'(r - 26);
        if (r < 62)
            return CH_DIG_0 + 8'(r - 52);
        if (r == 62)
            return CH_DASH;
        return CH_UNDER;
    endfunction

    function automatic logic [NAME_W-1:0] name_of(input string s);
        logic [NAME_W-1:0] name;
        int i;
        name = '0;
        for (i = 0; i < s.len() && i < NAME_CHARS; i++)
            name[8*i +: 8] = s[i];
        return name;
    endfunction

    // Fills the bytes past the length with either zeros or random junk.
    function automatic logic [NAME_W-1:0] dress_name(input logic [NAME_W-1:0] name,
                                                      input int n);
        logic [NAME_W-1:0] dressed;
        logic junk;
        int i;
        dressed = name;
        junk = 1'($urandom_range(0, 1));
        for (i = n; i < NAME_CHARS; i++)
            dressed[8*i +: 8] = junk ? 8'($urandom_range(0, 255)) : 8'h00;
        return dressed;
    endfunction

    // Offers one transaction, waits for the handshake, then idles for a random gap.
    task automatic send_request(input logic kind, input logic [NAME_W-1:0] name,
                                input logic [LEN_W-1:0] n, input logic signed [PID_W-1:0] pid,
                                input logic [LIVE_W-1:0] live);
        int gap;
        req.valid     <= 1'b1;
        req.req_type  <= kind;
        req.name_lo   <= name[LO_W-1:0];
        req.name_hi   <= name[NAME_W-1:LO_W];
        req.name_len  <= n;
        req.proc_id   <= pid;
        req.live_mask <= live;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
        gap = tx_steady ? 0 : idle_span();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender until every response has been taken.
    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Processes start and die at random; once in a while the whole mask is redrawn.
    task automatic evolve_world();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            world_live[pick_pid()] = 1'b0;
        else if (r < 12)
            world_live[pick_pid()] = 1'b1;
        else if (r == 12)
            world_live = {$urandom, $urandom};
    endtask

    // One random transaction: mostly well-formed registers and lookups on pooled names.
    task automatic random_item();
        int k;
        int r;
        int p;
        int pos;
        logic [NAME_W-1:0] name;
        logic [LIVE_W-1:0] live;
        logic [LEN_W-1:0]  n;

        evolve_world();
        k = $urandom_range(0, POOL_SIZE - 1);
        n = LEN_W'(pool_len[k]);
        name = dress_name(pool_name[k], pool_len[k]);
        live = world_live;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            p = pick_pid();
            world_live[p] = 1'b1;
            send_request(REQ_REGISTER, name, n, PID_W'(p), world_live);
        end
        else if (r < 80)
        begin
            send_request(REQ_LOOKUP, name, n, PID_W'($urandom), world_live);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    if ($urandom_range(0, 1))
                        live = {$urandom, $urandom};
                    send_request(1'($urandom), NAME_W'({$urandom, $urandom, $urandom, $urandom}),
                                 LEN_W'($urandom), PID_W'($urandom), live);
                end
                1:
                begin
                    pos = $urandom_range(0, pool_len[k] - 1);
                    name[8*pos +: 8] = BAD_BYTES[$urandom_range(0, 11)];
                    p = pick_pid();
                    world_live[p] = 1'b1;
                    send_request(REQ_REGISTER, name, n, PID_W'(p), world_live);
                end
                2:
                begin
                    send_request(REQ_REGISTER, name, n, PID_W'(-$urandom_range(1, 64)), live);
                end
                3:
                begin
                    p = pick_pid();
                    live[p] = 1'b0;
                    send_request(REQ_REGISTER, name, n, PID_W'(p), live);
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        n = '0;
                    else
                        n = LEN_W'($urandom_range(NAME_CHARS + 1, 31));
                    send_request(1'($urandom), name, n, PID_W'($urandom), live);
                end
            endcase
        end
    endtask

    // Receiver: random stalls, steady stretches, and one long hold-off on request.
    initial
    begin : rx_side
        int run_len;
        int stall_len;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold)
            begin
                rx_hold = 1'b0;
                rsp.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                run_len = $urandom_range(1, 16);
                repeat (run_len) @(posedge clk);
                stall_len = rx_steady ? 0 : idle_span();
                if (stall_len > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (stall_len) @(posedge clk);
                end
            end
        end
    end

    // Stimulus: reset, directed cases, a full table, then random phases.
    initial
    begin : stimulus
        logic [LIVE_W-1:0] all_live;
        string tag;
        int ph;
        int i;
        int k;

        all_live = '1;
        world_live = '1;
        rst_n = 1'b0;
        req.valid     <= 1'b0;
        req.req_type  <= REQ_REGISTER;
        req.name_lo   <= '0;
        req.name_hi   <= '0;
        req.name_len  <= '0;
        req.proc_id   <= '0;
        req.live_mask <= '0;

        for (k = 0; k < POOL_SIZE; k++)
        begin
            pool_len[k] = (k < NAME_CHARS) ? k + 1 : $urandom_range(1, NAME_CHARS);
            for (i = 0; i < NAME_CHARS; i++)
                pool_name[k][8*i +: 8] = legal_char();
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty names, overlong names, bad bytes and bad pids are all turned away.
        send_request(REQ_LOOKUP, name_of("svc"), 5'd0, 7'sd0, all_live);
        send_request(REQ_REGISTER, name_of("svc"), 5'd0, 7'sd1, all_live);
        send_request(REQ_REGISTER, name_of("overlong_name15"), 5'd16, 7'sd1, all_live);
        send_request(REQ_REGISTER, name_of("overlong"), 5'd31, 7'sd1, all_live);
        send_request(REQ_REGISTER, name_of("ab"), 5'd3, 7'sd1, all_live);
        send_request(REQ_REGISTER, name_of("neg"), 5'd3, -7'sd1, all_live);
        send_request(REQ_REGISTER, name_of("dead"), 5'd4, 7'sd9, all_live & ~(64'd1 << 9));

        // Shortest and longest names, lowest and highest pids.
        send_request(REQ_REGISTER, name_of("A"), 5'd1, 7'sd0, all_live);
        send_request(REQ_REGISTER, name_of("zZ09-_azAZ-_9a0"), 5'd15, 7'sd63, all_live);

        // Junk past the length is ignored; a match is rewritten even if its process died.
        send_request(REQ_REGISTER, name_of("mid_name9") | {48'h3C11FF007E2A, 72'h0}, 5'd9,
                     7'sd5, all_live);
        send_request(REQ_LOOKUP, name_of("mid_name9") | {48'hC3EE00FF81D5, 72'h0}, 5'd9,
                     -7'sd1, all_live);
        send_request(REQ_REGISTER, name_of("mid_name9"), 5'd9, 7'sd6, all_live & ~(64'd1 << 5));

        // Fill the remaining slots, then one more name finds the table full.
        for (k = 0; k < SLOTS_DEF - 2; k++)
        begin
            tag = $sformatf("fill%0d", k);
            send_request(REQ_REGISTER, name_of(tag), LEN_W'(tag.len()), PID_W'(k + 1), all_live);
        end

        // An overlong lookup frees the dead slot but matches nothing; the name is then gone.
        send_request(REQ_LOOKUP, name_of("A"), 5'd16, 7'sd0, all_live & ~64'd1);
        send_request(REQ_LOOKUP, name_of("A"), 5'd1, 7'sd0, all_live);
        wait_drained();

        // Second phase runs without idling; the third opens with a burst into a stalled receiver.
        for (ph = 0; ph < PHASES; ph++)
        begin
            rx_steady = (ph == 1);
            if (ph == 2)
                rx_hold = 1'b1;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                tx_steady = (ph == 1) || (ph == 2 && i < BURST_ITEMS);
                random_item();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d requests; %0d registrations granted, %0d lookups hit a live name.",
                 sent, reg_granted, lookup_hits);
        $display("Checked %0d responses across directed cases, a full table and stall phases.",
                 checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("Timeout: requests or responses stopped moving");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/nsr_pkg.sv
rtl/core/nsr_req_if.sv
rtl/core/nsr_rsp_if.sv
rtl/core/nsr_ram.sv
rtl/core/nsr_front.sv
rtl/core/nsr_back.sv
rtl/core/named_service_registry_table.sv
tb/nsr_registry_checker.sv
tb/tb_named_service_registry_table.sv
